FILE: hdl/rfrp_pkg.sv
// Shared definitions for the render FIFO and RAM port.
// Holds the register map, operation codes and the response record.
// Used by every module under hdl/.
package rfrp_pkg;

  localparam int unsigned FIFO_DEPTH_DEFAULT    = 2048;
  localparam int unsigned RAM_ADDR_BITS_DEFAULT = 16;

  localparam int unsigned DATA_W   = 32;
  localparam int unsigned HALF_W   = 16;
  localparam int unsigned OFS_W    = 9;
  localparam int unsigned BANK_BIT = 22;

  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  localparam logic [OFS_W-1:0] OFS_FIFO_HI      = 9'h000;
  localparam logic [OFS_W-1:0] OFS_FIFO_LO      = 9'h001;
  localparam logic [OFS_W-1:0] OFS_STATUS       = 9'h11b;
  localparam logic [OFS_W-1:0] OFS_SLAVE_STATUS = 9'h11c;
  localparam logic [OFS_W-1:0] OFS_CLEAR        = 9'h11d;
  localparam logic [OFS_W-1:0] OFS_POINTER      = 9'h11e;
  localparam logic [OFS_W-1:0] OFS_RAM_DATA     = 9'h11f;

  localparam logic [HALF_W-1:0] STATUS_VALUE = 16'h8000;

  // Source of read_data for a finished transaction.
  typedef enum logic [2:0] {
    SRC_ZERO    = 3'd0,
    SRC_FIFO_HI = 3'd1,
    SRC_FIFO_LO = 3'd2,
    SRC_STATUS  = 3'd3,
    SRC_RAM     = 3'd4
  } src_t;

  typedef struct packed {
    logic valid;
    src_t src;
    logic flag_update;
    logic flag_level;
    logic unmapped;
  } rsp_t;

endpackage

FILE: hdl/rfrp_fifo_mem.sv
// FIFO word store: one write port and one read port, registered read data.
// Depends on rfrp_pkg for the data width.
module rfrp_fifo_mem #(
  parameter int unsigned FIFO_DEPTH = rfrp_pkg::FIFO_DEPTH_DEFAULT,
  localparam int unsigned IW = $clog2(FIFO_DEPTH)
) (
  input  logic                         clk,
  input  logic                         wr_en,
  input  logic [IW-1:0]                wr_addr,
  input  logic [rfrp_pkg::DATA_W-1:0]  wr_data,
  input  logic                         rd_en,
  input  logic [IW-1:0]                rd_addr,
  output logic [rfrp_pkg::DATA_W-1:0]  rd_data
);

  logic [rfrp_pkg::DATA_W-1:0] mem [FIFO_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: hdl/rfrp_ram_mem.sv
// Two 16-bit RAM banks held as one single-port memory; the bank select
// is the top address bit. Depends on rfrp_pkg for the data width.
module rfrp_ram_mem #(
  parameter int unsigned RAM_ADDR_BITS = rfrp_pkg::RAM_ADDR_BITS_DEFAULT,
  localparam int unsigned AW = RAM_ADDR_BITS + 1
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic                         we,
  input  logic [AW-1:0]                addr,
  input  logic [rfrp_pkg::HALF_W-1:0]  wdata,
  output logic [rfrp_pkg::HALF_W-1:0]  rdata
);

  logic [rfrp_pkg::HALF_W-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

FILE: hdl/rfrp_ctrl.sv
// Register decode, FIFO indexes and RAM pointer; drives both memories and
// registers the response record. Depends on rfrp_pkg.
module rfrp_ctrl #(
  parameter int unsigned FIFO_DEPTH    = rfrp_pkg::FIFO_DEPTH_DEFAULT,
  parameter int unsigned RAM_ADDR_BITS = rfrp_pkg::RAM_ADDR_BITS_DEFAULT,
  localparam int unsigned IW = $clog2(FIFO_DEPTH),
  localparam int unsigned AW = RAM_ADDR_BITS + 1
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic                         operation,
  input  logic [rfrp_pkg::OFS_W-1:0]   reg_offset,
  input  logic [rfrp_pkg::DATA_W-1:0]  write_data,
  output logic                         fifo_wr_en,
  output logic [IW-1:0]                fifo_wr_addr,
  output logic [rfrp_pkg::DATA_W-1:0]  fifo_wr_data,
  output logic                         fifo_rd_en,
  output logic [IW-1:0]                fifo_rd_addr,
  output logic                         ram_en,
  output logic                         ram_we,
  output logic [AW-1:0]                ram_addr,
  output logic [rfrp_pkg::HALF_W-1:0]  ram_wdata,
  output rfrp_pkg::rsp_t               rsp
);

  localparam logic [IW:0]   HALF = (IW+1)'(FIFO_DEPTH / 2);
  localparam logic [IW-1:0] LAST = IW'(FIFO_DEPTH - 1);

  logic [IW-1:0]               head, head_next;
  logic [IW-1:0]               tail, tail_next;
  logic [rfrp_pkg::DATA_W-1:0] ptr, ptr_next;
  rfrp_pkg::rsp_t              rsp_next;

  always_comb begin
    head_next    = head;
    tail_next    = tail;
    ptr_next     = ptr;
    fifo_wr_en   = 1'b0;
    fifo_rd_en   = 1'b0;
    ram_en       = 1'b0;
    ram_we       = 1'b0;
    rsp_next     = '0;
    rsp_next.src = rfrp_pkg::SRC_ZERO;
    if (start) begin
      rsp_next.valid = 1'b1;
      if (operation == rfrp_pkg::OP_READ) begin
        unique case (reg_offset)
          rfrp_pkg::OFS_FIFO_HI: begin
            fifo_rd_en   = 1'b1;
            rsp_next.src = rfrp_pkg::SRC_FIFO_HI;
          end
          rfrp_pkg::OFS_FIFO_LO: begin
            fifo_rd_en           = 1'b1;
            rsp_next.src         = rfrp_pkg::SRC_FIFO_LO;
            rsp_next.flag_update = 1'b1;
            rsp_next.flag_level  = !(({1'b0, head} + (IW+1)'(1)) < HALF);
            head_next            = (head == LAST) ? '0 : head + IW'(1);
          end
          rfrp_pkg::OFS_STATUS, rfrp_pkg::OFS_SLAVE_STATUS: begin
            rsp_next.src = rfrp_pkg::SRC_STATUS;
          end
          rfrp_pkg::OFS_RAM_DATA: begin
            ram_en       = 1'b1;
            rsp_next.src = rfrp_pkg::SRC_RAM;
            ptr_next     = ptr + 32'd1;
          end
          default: begin
            rsp_next.unmapped = 1'b1;
          end
        endcase
      end else begin
        unique case (reg_offset)
          rfrp_pkg::OFS_FIFO_HI: begin
            fifo_wr_en           = 1'b1;
            rsp_next.flag_update = 1'b1;
            rsp_next.flag_level  = {1'b0, tail} < HALF;
            tail_next            = (tail == LAST) ? '0 : tail + IW'(1);
          end
          rfrp_pkg::OFS_CLEAR: begin
            head_next = '0;
            tail_next = '0;
          end
          rfrp_pkg::OFS_POINTER: begin
            ptr_next = write_data;
          end
          rfrp_pkg::OFS_RAM_DATA: begin
            ram_en   = 1'b1;
            ram_we   = 1'b1;
            ptr_next = ptr + 32'd1;
          end
          default: begin
            rsp_next.unmapped = 1'b1;
          end
        endcase
      end
    end
  end

  assign fifo_wr_addr = tail;
  assign fifo_wr_data = write_data;
  assign fifo_rd_addr = head;
  assign ram_addr     = {ptr[rfrp_pkg::BANK_BIT], ptr[RAM_ADDR_BITS-1:0]};
  assign ram_wdata    = write_data[rfrp_pkg::HALF_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
      ptr  <= '0;
      rsp  <= '0;
    end else begin
      head <= head_next;
      tail <= tail_next;
      ptr  <= ptr_next;
      rsp  <= rsp_next;
    end
  end

endmodule

FILE: hdl/render_fifo_and_ram_port.sv
// Top level of the render FIFO and RAM port.
// Depends on rfrp_pkg, rfrp_ctrl, rfrp_fifo_mem and rfrp_ram_mem.
//
// Usage: a bus access (operation, reg_offset, write_data) is a transaction
// taken at a rising edge where start is high and busy is low. busy stays
// low, so a new transaction may be issued on every clock.
// Each transaction returns exactly one result (read_data, flag_update,
// flag_level, unmapped_access), shown for one cycle with done high in the
// cycle right after the transaction is taken, at a throughput of one
// transaction per cycle. The result waits on the registered read of the
// FIFO and RAM memories; index, pointer and memory
// writes all take effect at the accepting edge, so the next transaction
// sees them.
// The receiver cannot stall; a result is gone after its one cycle.
// Reset clears the FIFO head and tail indexes, the RAM pointer and done.
// Memory contents are not cleared; reading an entry never written since
// reset gives an unspecified value.
module render_fifo_and_ram_port #(
  parameter int unsigned FIFO_DEPTH    = rfrp_pkg::FIFO_DEPTH_DEFAULT,
  parameter int unsigned RAM_ADDR_BITS = rfrp_pkg::RAM_ADDR_BITS_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic                         operation,
  input  logic [rfrp_pkg::OFS_W-1:0]   reg_offset,
  input  logic [rfrp_pkg::DATA_W-1:0]  write_data,
  output logic                         done,
  output logic [rfrp_pkg::HALF_W-1:0]  read_data,
  output logic                         flag_update,
  output logic                         flag_level,
  output logic                         unmapped_access
);

  localparam int unsigned IW = $clog2(FIFO_DEPTH);
  localparam int unsigned AW = RAM_ADDR_BITS + 1;

  logic                         fifo_wr_en;
  logic [IW-1:0]                fifo_wr_addr;
  logic [rfrp_pkg::DATA_W-1:0]  fifo_wr_data;
  logic                         fifo_rd_en;
  logic [IW-1:0]                fifo_rd_addr;
  logic [rfrp_pkg::DATA_W-1:0]  fifo_rd_data;
  logic                         ram_en;
  logic                         ram_we;
  logic [AW-1:0]                ram_addr;
  logic [rfrp_pkg::HALF_W-1:0]  ram_wdata;
  logic [rfrp_pkg::HALF_W-1:0]  ram_rdata;
  rfrp_pkg::rsp_t               rsp;

  rfrp_ctrl #(
    .FIFO_DEPTH    (FIFO_DEPTH),
    .RAM_ADDR_BITS (RAM_ADDR_BITS)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .operation    (operation),
    .reg_offset   (reg_offset),
    .write_data   (write_data),
    .fifo_wr_en   (fifo_wr_en),
    .fifo_wr_addr (fifo_wr_addr),
    .fifo_wr_data (fifo_wr_data),
    .fifo_rd_en   (fifo_rd_en),
    .fifo_rd_addr (fifo_rd_addr),
    .ram_en       (ram_en),
    .ram_we       (ram_we),
    .ram_addr     (ram_addr),
    .ram_wdata    (ram_wdata),
    .rsp          (rsp)
  );

  rfrp_fifo_mem #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_fifo_mem (
    .clk     (clk),
    .wr_en   (fifo_wr_en),
    .wr_addr (fifo_wr_addr),
    .wr_data (fifo_wr_data),
    .rd_en   (fifo_rd_en),
    .rd_addr (fifo_rd_addr),
    .rd_data (fifo_rd_data)
  );

  rfrp_ram_mem #(
    .RAM_ADDR_BITS (RAM_ADDR_BITS)
  ) u_ram_mem (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // The port never holds off, so busy is tied low.
  assign busy = 1'b0;

  assign done            = rsp.valid;
  assign flag_update     = rsp.flag_update;
  assign flag_level      = rsp.flag_level;
  assign unmapped_access = rsp.unmapped;

  always_comb begin
    unique case (rsp.src)
      rfrp_pkg::SRC_FIFO_HI: read_data = fifo_rd_data[rfrp_pkg::DATA_W-1:rfrp_pkg::HALF_W];
      rfrp_pkg::SRC_FIFO_LO: read_data = fifo_rd_data[rfrp_pkg::HALF_W-1:0];
      rfrp_pkg::SRC_STATUS:  read_data = rfrp_pkg::STATUS_VALUE;
      rfrp_pkg::SRC_RAM:     read_data = ram_rdata;
      default:               read_data = '0;
    endcase
  end

endmodule
